// ===== rtl/brld_pkg.sv =====
// ----------------------------------------------------------------------------
// brld_pkg
// Shared types and constants of the boot ROM LFSR descrambler.
// ----------------------------------------------------------------------------
package brld_pkg;

  localparam int unsigned OFFSET_W = 21;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned LFSR_W   = 16;

  localparam logic [LFSR_W-1:0] SEED_T = 16'h2953;
  localparam logic [LFSR_W-1:0] SEED_U = 16'hd9c2;
  localparam logic [LFSR_W-1:0] SEED_V = 16'h3ff1;
  localparam logic [LFSR_W-1:0] TAP_T  = 16'ha740;
  localparam logic [LFSR_W-1:0] TAP_U  = 16'hfb10;
  localparam logic [LFSR_W-1:0] TAP_V  = 16'hb3d0;

  localparam logic [OFFSET_W-1:0] KEY_START = 21'h000100;
  localparam logic [OFFSET_W-1:0] KEY_LIMIT = 21'h1aff00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GEN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic reseed;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic keyed;
    logic key_gt;
    logic key_lt;
    logic bit_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/brld_ctrl.sv =====
// ----------------------------------------------------------------------------
// brld_ctrl
// Sequencer: takes an item and, for a keyed item, reseeds if needed and runs the
// keystream generator until the key byte of the item's position is ready, then hands the result on.
// ----------------------------------------------------------------------------
module brld_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  brld_pkg::status_t status_i,
  output brld_pkg::cmd_t    cmd_o
);
  import brld_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!status_i.keyed) begin
          state_d = ST_OUT;
        end else if (!status_i.key_gt) begin
          state_d = ST_GEN;
        end
      end
      ST_GEN: begin
        if (status_i.bit_last && !status_i.key_lt) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      ST_CHECK: begin
        cmd_o.reseed = status_i.keyed && status_i.key_gt;
      end
      ST_GEN: begin
        cmd_o.step = 1'b1;
      end
      ST_OUT: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/brld_dp.sv =====
// ----------------------------------------------------------------------------
// brld_dp
// Datapath: start offset register, positions, three-LFSR keystream generator,
// item buffer and output register.
// ----------------------------------------------------------------------------
module brld_dp #(
  parameter int unsigned POSITION_BITS = 21
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_offset_we_i,
  input  logic [brld_pkg::OFFSET_W-1:0]          start_offset_i,
  input  logic [brld_pkg::DATA_W-1:0]            data_in_i,
  input  logic                                   end_of_run_i,
  input  brld_pkg::cmd_t                         cmd_i,
  output brld_pkg::status_t                      status_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [brld_pkg::DATA_W-1:0]            data_out_o,
  output logic                                   end_of_run_out_o
);
  import brld_pkg::*;

  localparam logic [POSITION_BITS-1:0] KeyStart = POSITION_BITS'(KEY_START);
  localparam logic [POSITION_BITS-1:0] KeyLimit = POSITION_BITS'(KEY_LIMIT);

  logic [OFFSET_W-1:0]      start_offset_q;
  logic [POSITION_BITS-1:0] data_pos_q, data_pos_d;
  logic [POSITION_BITS-1:0] key_pos_q, key_pos_d;
  logic                     run_active_q, run_active_d;
  logic [LFSR_W-1:0]        shift_t_q, shift_t_d;
  logic [LFSR_W-1:0]        shift_u_q, shift_u_d;
  logic [LFSR_W-1:0]        shift_v_q, shift_v_d;
  logic                     mix_q, mix_d;
  logic [DATA_W-1:0]        key_byte_q, key_byte_d;
  logic [2:0]               bit_cnt_q, bit_cnt_d;
  logic [DATA_W-1:0]        data_q;
  logic                     last_q;
  logic                     out_valid_q, out_valid_d;
  logic [DATA_W-1:0]        out_data_q;
  logic                     out_last_q;

  logic a0, a1, b0, b1, c0, mix_next;
  logic keyed;

  assign keyed = (data_pos_q >= KeyStart) && (data_pos_q < KeyLimit);

  assign a0 = shift_t_q[0];
  assign a1 = shift_t_q[1];
  assign b0 = shift_u_q[0];
  assign b1 = shift_u_q[1];
  assign c0 = shift_v_q[0];
  assign mix_next = mix_q ^ a1 ^ c0 ^ (b0 | b1) ^ ((a0 ^ b1 ^ c0) & (a0 ^ b0));

  always_comb begin
    data_pos_d   = data_pos_q;
    key_pos_d    = key_pos_q;
    run_active_d = run_active_q;
    shift_t_d    = shift_t_q;
    shift_u_d    = shift_u_q;
    shift_v_d    = shift_v_q;
    mix_d        = mix_q;
    key_byte_d   = key_byte_q;
    bit_cnt_d    = bit_cnt_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    if ((cmd_i.load && !run_active_q) || cmd_i.reseed) begin
      shift_t_d  = SEED_T;
      shift_u_d  = SEED_U;
      shift_v_d  = SEED_V;
      mix_d      = 1'b1;
      key_byte_d = '0;
      key_pos_d  = KeyStart;
    end
    if (cmd_i.load && !run_active_q) begin
      data_pos_d   = POSITION_BITS'(start_offset_q);
      run_active_d = 1'b1;
    end

    if (cmd_i.step) begin
      mix_d      = mix_next;
      key_byte_d = {key_byte_q[DATA_W-2:0], mix_next};
      if (a0 == b0) begin
        shift_v_d = (shift_v_q >> 1) ^ (c0 ? TAP_V : '0);
      end
      if (!a0) begin
        shift_u_d = (shift_u_q >> 1) ^ (b0 ? TAP_U : '0);
      end
      shift_t_d = (shift_t_q >> 1) ^ (a0 ? TAP_T : '0);
      bit_cnt_d = bit_cnt_q + 3'd1;
      if (bit_cnt_q == 3'd7) begin
        key_pos_d = key_pos_q + POSITION_BITS'(1);
      end
    end

    if (cmd_i.emit) begin
      data_pos_d  = data_pos_q + POSITION_BITS'(1);
      out_valid_d = 1'b1;
      if (last_q) begin
        run_active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_offset_q <= '0;
      data_pos_q     <= '0;
      key_pos_q      <= KeyStart;
      run_active_q   <= 1'b0;
      shift_t_q      <= SEED_T;
      shift_u_q      <= SEED_U;
      shift_v_q      <= SEED_V;
      mix_q          <= 1'b1;
      key_byte_q     <= '0;
      bit_cnt_q      <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (start_offset_we_i) begin
        start_offset_q <= start_offset_i;
      end
      data_pos_q   <= data_pos_d;
      key_pos_q    <= key_pos_d;
      run_active_q <= run_active_d;
      shift_t_q    <= shift_t_d;
      shift_u_q    <= shift_u_d;
      shift_v_q    <= shift_v_d;
      mix_q        <= mix_d;
      key_byte_q   <= key_byte_d;
      bit_cnt_q    <= bit_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      data_q <= data_in_i;
      last_q <= end_of_run_i;
    end
    if (cmd_i.emit) begin
      out_data_q <= keyed ? (data_q ^ key_byte_q) : data_q;
      out_last_q <= last_q;
    end
  end

  assign status_o.keyed    = keyed;
  assign status_o.key_gt   = key_pos_q > data_pos_q;
  assign status_o.key_lt   = key_pos_q < data_pos_q;
  assign status_o.bit_last = bit_cnt_q == 3'd7;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign data_out_o       = out_data_q;
  assign end_of_run_out_o = out_last_q;

  a_key_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && keyed |-> key_pos_q == data_pos_q + POSITION_BITS'(1))
    else $error("key byte does not belong to the emitted item");

  a_reseed_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.reseed |=> key_pos_q == KeyStart)
    else $error("reseed did not restart the key position");

  a_lfsr_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_t_q != '0)
    else $error("keystream register t collapsed to zero");

endmodule

// ===== rtl/boot_rom_lfsr_descrambler.sv =====
// ----------------------------------------------------------------------------
// boot_rom_lfsr_descrambler
// Descrambles a run of boot ROM bytes with a three-LFSR keystream.
//
// The input channel (in_valid_i / in_ready_o) takes one scrambled byte per
// item with an end-of-run mark. The output channel (out_valid_o / out_ready_i)
// gives one descrambled byte per item, in order. start_offset_i is to be
// written with start_offset_we_i while the block is idle; the block itself
// does not enforce this. It gives the absolute ROM position of the first
// byte of each run. An item outside the keyed region goes from load
// through check straight to output. A keyed item in sequence takes eight
// steps of the one-bit keystream generator plus load, check and output.
// The first keyed item of a run, or one after a position wrap, first runs
// the generator forward to its position, eight steps per skipped byte; after
// a wrap, a reseed first restarts the generator from its seeds.
// The next item is taken only once the last one is in the output register.
// The output register frees the input side: a new item is taken while a
// result still waits. If the receiver stalls, the next finished item waits
// inside until the output register is free.
// Reset returns the generator to its seeds, the block to idle and the start
// offset to zero.
// ----------------------------------------------------------------------------
module boot_rom_lfsr_descrambler #(
  parameter int unsigned POSITION_BITS = 21
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_offset_we_i,
  input  logic [brld_pkg::OFFSET_W-1:0] start_offset_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [brld_pkg::DATA_W-1:0]   data_in_i,
  input  logic                          end_of_run_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [brld_pkg::DATA_W-1:0]   data_out_o,
  output logic                          end_of_run_out_o
);
  import brld_pkg::*;

  cmd_t    cmd;
  status_t status;

  brld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  brld_dp #(
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_offset_we_i (start_offset_we_i),
    .start_offset_i    (start_offset_i),
    .data_in_i         (data_in_i),
    .end_of_run_i      (end_of_run_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .data_out_o        (data_out_o),
    .end_of_run_out_o  (end_of_run_out_o)
  );

endmodule
